>>> hw/rtl/kars_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat scanner package
// Shared widths, register indexes, the configuration bundle and the report
// update for one fire.
// ----------------------------------------------------------------------------
package kars_pkg;

    // Width of every configuration register.
    localparam int CFG_W = 16;
    // Width of the register index on the configuration port.
    localparam int CFG_IDX_W = 3;
    // Width of the report word and of the key level word.
    localparam int REPORT_W = 8;

    // Repeat mark ORed into the report on every fire.
    localparam logic [REPORT_W-1:0] REPEAT_MARK = 8'h80;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BAND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_BAND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_IVL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_IVL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_IVL     = 3'd5;

    // Current configuration, handed from the register file to the sequencer.
    typedef struct packed {
        logic [CFG_W-1:0] first_repeat_ticks;
        logic [CFG_W-1:0] medium_band_ticks;
        logic [CFG_W-1:0] fast_band_ticks;
        logic [CFG_W-1:0] slow_interval;
        logic [CFG_W-1:0] medium_interval;
        logic [CFG_W-1:0] fast_interval;
    } t_cfg;

    // A fire ORs in the key bit and the repeat mark, then adds one modulo 256.
    function automatic logic [REPORT_W-1:0] fire_report(
        input logic [REPORT_W-1:0] report,
        input logic [REPORT_W-1:0] key_bit
    );
        logic [REPORT_W-1:0] marked;
        marked = report | key_bit | REPEAT_MARK;
        return marked + 8'd1;
    endfunction

endpackage

>>> hw/rtl/kars_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat scanner configuration registers
// Six 16-bit registers written by index; an unknown index is ignored.
// ----------------------------------------------------------------------------
module kars_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kars_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kars_pkg::CFG_W-1:0]       i_cfg_data,
    output kars_pkg::t_cfg                   o_cfg
);
    import kars_pkg::*;

    t_cfg r_cfg;

    // The register file takes a word in every cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes, with the documented reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_repeat_ticks <= 16'd20;
            r_cfg.medium_band_ticks  <= 16'd100;
            r_cfg.fast_band_ticks    <= 16'd200;
            r_cfg.slow_interval      <= 16'd10;
            r_cfg.medium_interval    <= 16'd5;
            r_cfg.fast_interval      <= 16'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_REPEAT: r_cfg.first_repeat_ticks <= i_cfg_data;
                CFG_MEDIUM_BAND:  r_cfg.medium_band_ticks  <= i_cfg_data;
                CFG_FAST_BAND:    r_cfg.fast_band_ticks    <= i_cfg_data;
                CFG_SLOW_IVL:     r_cfg.slow_interval      <= i_cfg_data;
                CFG_MEDIUM_IVL:   r_cfg.medium_interval    <= i_cfg_data;
                CFG_FAST_IVL:     r_cfg.fast_interval      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/kars_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat scanner remainder unit
// Restoring division, one dividend bit per cycle, reporting whether the
// remainder is zero. The divisor must be non-zero.
// ----------------------------------------------------------------------------
module kars_rem #(
    parameter int DIVIDEND_W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DIVIDEND_W-1:0]        i_dividend,
    input  logic [kars_pkg::CFG_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic                         o_zero
);
    import kars_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_dvd;
    logic [CFG_W-1:0]      r_div;
    logic [CFG_W-1:0]      r_rem;
    logic [STEP_W-1:0]     r_steps;
    logic                  r_done;
    logic [CFG_W:0]        trial;

    // Partial remainder with the next dividend bit shifted in.
    assign trial  = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign o_done = r_done;
    assign o_zero = (r_rem == '0);

    // Control: step count and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_steps <= STEP_W'(DIVIDEND_W);
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_steps == STEP_W'(1));
            if (r_steps != '0) begin
                r_steps <= r_steps - STEP_W'(1);
            end
        end
    end

    // Datapath: one compare and subtract per step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_steps != '0) begin
            r_dvd <= r_dvd << 1;
            if (trial >= {1'b0, r_div}) begin
                r_rem <= CFG_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= CFG_W'(trial);
            end
        end
    end

endmodule

>>> hw/rtl/key_autorepeat_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key auto-repeat scanner
// Per-key held-time counters with a three-band accelerating repeat.
// ----------------------------------------------------------------------------
// Each input word is one scan of active-low key levels and yields exactly one
// report word. The keys are walked one at a time by a small sequencer: the
// scan is taken in S_IDLE, a released key is handled in S_KEY, a held key in
// S_KEY and S_BAND, and a held key whose count lies in a repeat band and whose
// interval is non-zero also waits in S_DIV for the shared bit-serial remainder
// unit; S_DONE then hands the report to the output register. A scan may also
// wait for the previous report word to leave the output register, and no new
// scan is taken until the sequencer is back in S_IDLE. A finished report may
// wait in the output register while the next scan is taken.
// ----------------------------------------------------------------------------
module key_autorepeat_scanner #(
    parameter int KEY_COUNT    = 8,
    parameter int COUNTER_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [kars_pkg::REPORT_W-1:0]    i_key_levels,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [kars_pkg::REPORT_W-1:0]    o_key_report,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kars_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kars_pkg::CFG_W-1:0]       i_cfg_data
);
    import kars_pkg::*;

    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_KEY  = 5'b00010,
        S_BAND = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_cfg                    cfg;
    t_state                  r_state, n_state;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [KEY_COUNT-1:0]    r_levels;
    logic [REPORT_W-1:0]     r_report, n_report;
    logic [COUNTER_BITS-1:0] r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic [REPORT_W-1:0]     r_out_data, n_out_data;
    logic [COUNTER_BITS-1:0] r_counters [KEY_COUNT];
    logic                    wr_en;
    logic [COUNTER_BITS-1:0] wr_data;
    logic                    rem_start;
    logic [CFG_W-1:0]        rem_period;
    logic                    rem_done;
    logic                    rem_zero;
    logic [COUNTER_BITS-1:0] cur_cnt;
    logic [REPORT_W-1:0]     key_bit;
    logic                    last_key;
    logic [CMP_W-1:0]        cx, c_first, c_med, c_fast;

    // Configuration register file.
    kars_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Shared remainder unit for the repeat interval test.
    kars_rem #(
        .DIVIDEND_W (COUNTER_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_cnt),
        .i_divisor  (rem_period),
        .o_done     (rem_done),
        .o_zero     (rem_zero)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_key_report = r_out_data;

    assign cur_cnt  = r_counters[r_key];
    assign key_bit  = REPORT_W'(1) << r_key;
    assign last_key = (r_key == KEY_W'(KEY_COUNT - 1));
    assign cx       = CMP_W'(r_cnt);
    assign c_first  = CMP_W'(cfg.first_repeat_ticks);
    assign c_med    = CMP_W'(cfg.medium_band_ticks);
    assign c_fast   = CMP_W'(cfg.fast_band_ticks);

    // Sequencer: walk the keys, one counter update and test at a time.
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_report    = r_report;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_data     = '0;
        rem_start   = 1'b0;
        rem_period  = cfg.slow_interval;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = '0;
                    n_report = '0;
                    n_state  = S_KEY;
                end
            end

            S_KEY: begin
                wr_en = 1'b1;
                if (!r_levels[r_key]) begin
                    // Held: count one more scan, then test the bands.
                    n_cnt   = cur_cnt + COUNTER_BITS'(1);
                    wr_data = n_cnt;
                    n_state = S_BAND;
                end else begin
                    // Released: a short hold reports the key bit alone.
                    if (cur_cnt != '0 && CMP_W'(cur_cnt) < c_first) begin
                        n_report = r_report | key_bit;
                    end
                    wr_data = '0;
                    n_key   = last_key ? r_key : r_key + KEY_W'(1);
                    n_state = last_key ? S_DONE : S_KEY;
                end
            end

            S_BAND: begin
                n_key   = last_key ? r_key : r_key + KEY_W'(1);
                n_state = last_key ? S_DONE : S_KEY;
                if (cx == c_first) begin
                    n_report = fire_report(r_report, key_bit);
                end else begin
                    // Pick the interval of the band the count lies in.
                    if (cx > c_first && cx < c_med) begin
                        rem_period = cfg.slow_interval;
                        rem_start  = (cfg.slow_interval != '0);
                    end else if (cx >= c_med && cx < c_fast) begin
                        rem_period = cfg.medium_interval;
                        rem_start  = (cfg.medium_interval != '0);
                    end else if (cx >= c_fast) begin
                        rem_period = cfg.fast_interval;
                        rem_start  = (cfg.fast_interval != '0);
                    end
                    if (rem_start) begin
                        n_key   = r_key;
                        n_state = S_DIV;
                    end
                end
            end

            S_DIV: begin
                if (rem_done) begin
                    if (rem_zero) begin
                        n_report = fire_report(r_report, key_bit);
                    end
                    n_key   = last_key ? r_key : r_key + KEY_W'(1);
                    n_state = last_key ? S_DONE : S_KEY;
                end
            end

            S_DONE: begin
                // Hand the report over once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_report;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and the held-time counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_counters[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_counters[r_key] <= wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_report   <= n_report;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
        if (r_state == S_IDLE && i_in_valid) begin
            r_levels <= i_key_levels[KEY_COUNT-1:0];
        end
    end

endmodule
